@@ sv/sts_pkg.sv @@
// Shared types, codes and constants for the session test state machine.
package sts_pkg;

    localparam int NUM_SESSIONS_DEF = 1024;

    // Field widths
    localparam int IDX_W   = 10;
    localparam int CMD_W   = 4;
    localparam int ST_W    = 5;
    localparam int Q_W     = 3;
    localparam int TACT_W  = 2;
    localparam int SECS_W  = 16;
    localparam int TUS_W   = 36;
    localparam int NOTE_W  = 2;
    localparam int CFG_A_W = 3;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 64;

    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

    // Session state codes
    localparam logic [ST_W-1:0] ST_CL_TO_INIT     = 5'd0;
    localparam logic [ST_W-1:0] ST_CL_TO_OPEN     = 5'd1;
    localparam logic [ST_W-1:0] ST_CL_OPENING     = 5'd2;
    localparam logic [ST_W-1:0] ST_CL_OPEN        = 5'd3;
    localparam logic [ST_W-1:0] ST_CL_SENDING     = 5'd4;
    localparam logic [ST_W-1:0] ST_CL_NO_SND_WIN  = 5'd5;
    localparam logic [ST_W-1:0] ST_CL_TO_CLOSE    = 5'd6;
    localparam logic [ST_W-1:0] ST_CL_CLOSING     = 5'd7;
    localparam logic [ST_W-1:0] ST_CL_CLOSED      = 5'd8;
    localparam logic [ST_W-1:0] ST_SRV_OPENING    = 5'd9;
    localparam logic [ST_W-1:0] ST_SRV_OPEN       = 5'd10;
    localparam logic [ST_W-1:0] ST_SRV_SENDING    = 5'd11;
    localparam logic [ST_W-1:0] ST_SRV_NO_SND_WIN = 5'd12;
    localparam logic [ST_W-1:0] ST_SRV_CLOSING    = 5'd13;
    localparam logic [ST_W-1:0] ST_SRV_CLOSED     = 5'd14;
    localparam logic [ST_W-1:0] ST_LISTEN         = 5'd15;
    localparam logic [ST_W-1:0] ST_PURGED         = 5'd16;

    // Commands
    localparam logic [CMD_W-1:0] CMD_START_CLIENT = 4'd0;
    localparam logic [CMD_W-1:0] CMD_START_SERVER = 4'd1;
    localparam logic [CMD_W-1:0] CMD_START_LISTEN = 4'd2;
    localparam logic [CMD_W-1:0] CMD_TIMER        = 4'd3;
    localparam logic [CMD_W-1:0] CMD_PURGE        = 4'd4;
    localparam logic [CMD_W-1:0] CMD_CONNECTING   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_CONNECTED    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_CLOSING      = 4'd7;
    localparam logic [CMD_W-1:0] CMD_CLOSED       = 4'd8;
    localparam logic [CMD_W-1:0] CMD_SEND_START   = 4'd9;
    localparam logic [CMD_W-1:0] CMD_SEND_STOP    = 4'd10;
    localparam logic [CMD_W-1:0] CMD_SND_WIN      = 4'd11;
    localparam logic [CMD_W-1:0] CMD_NO_SND_WIN   = 4'd12;

    // Queue removal codes
    localparam logic [Q_W-1:0] QR_NONE     = 3'd0;
    localparam logic [Q_W-1:0] QR_TO_INIT  = 3'd1;
    localparam logic [Q_W-1:0] QR_TO_OPEN  = 3'd2;
    localparam logic [Q_W-1:0] QR_TO_SEND  = 3'd3;
    localparam logic [Q_W-1:0] QR_TO_CLOSE = 3'd4;
    localparam logic [Q_W-1:0] QR_CLOSED   = 3'd5;

    // Queue addition codes
    localparam logic [Q_W-1:0] QA_NONE        = 3'd0;
    localparam logic [Q_W-1:0] QA_TO_INIT     = 3'd1;
    localparam logic [Q_W-1:0] QA_TO_OPEN     = 3'd2;
    localparam logic [Q_W-1:0] QA_TO_OPEN_NRS = 3'd3;
    localparam logic [Q_W-1:0] QA_TO_SEND     = 3'd4;
    localparam logic [Q_W-1:0] QA_TO_CLOSE    = 3'd5;
    localparam logic [Q_W-1:0] QA_CLOSED      = 3'd6;

    localparam logic [TACT_W-1:0] TACT_NONE   = 2'd0;
    localparam logic [TACT_W-1:0] TACT_SET    = 2'd1;
    localparam logic [TACT_W-1:0] TACT_CANCEL = 2'd2;

    localparam logic [NOTE_W-1:0] NOTE_NONE = 2'd0;
    localparam logic [NOTE_W-1:0] NOTE_UP   = 2'd1;
    localparam logic [NOTE_W-1:0] NOTE_DOWN = 2'd2;

    // Config register indexes
    localparam logic [CFG_A_W-1:0] CFG_START_DELAY = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_UPTIME      = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_UPTIME_INF  = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_DOWNTIME    = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_DOWN_INF    = 3'd4;

    typedef struct packed {
        logic [SECS_W-1:0] start_delay;
        logic [SECS_W-1:0] uptime;
        logic              uptime_inf;
        logic [SECS_W-1:0] downtime;
        logic              downtime_inf;
    } t_cfg;

    typedef struct packed {
        logic [ST_W-1:0]   st;
        logic              armed;
        logic [Q_W-1:0]    rem;
        logic [Q_W-1:0]    add;
        logic [TACT_W-1:0] tact;
        logic [SECS_W-1:0] secs;   // zero unless a timer is set
        logic [NOTE_W-1:0] note;
        logic              bad;
    } t_step;

endpackage

@@ sv/sts_next.sv @@
// Next-state logic: one session's transition for one command.
module sts_next (
    input  logic [sts_pkg::ST_W-1:0]  i_cur,
    input  logic                      i_armed,
    input  logic [sts_pkg::CMD_W-1:0] i_cmd,
    input  sts_pkg::t_cfg             i_cfg,
    output sts_pkg::t_step            o_step
);
    import sts_pkg::*;

    function automatic t_step f_arm(t_step s, logic [SECS_W-1:0] secs);
        t_step r;
        r = s;
        r.tact  = TACT_SET;
        r.secs  = secs;
        r.armed = 1'b1;
        return r;
    endfunction

    function automatic t_step f_disarm(t_step s);
        t_step r;
        r = s;
        if (r.armed) begin
            r.tact  = TACT_CANCEL;
            r.secs  = '0;
            r.armed = 1'b0;
        end
        return r;
    endfunction

    function automatic t_step f_purge(t_step s, logic [Q_W-1:0] rem);
        t_step r;
        r = f_disarm(s);
        r.rem = rem;
        r.st  = ST_PURGED;
        return r;
    endfunction

    function automatic t_step f_open_cl(t_step s, t_cfg c);
        t_step r;
        r = s;
        if (!c.uptime_inf) r = f_arm(r, c.uptime);
        r.st   = ST_CL_OPEN;
        r.note = NOTE_UP;
        return r;
    endfunction

    function automatic t_step f_closed_cl(t_step s, t_cfg c);
        t_step r;
        r = s;
        if (!c.downtime_inf) r = f_arm(r, c.downtime);
        r.add = QA_CLOSED;
        r.st  = ST_CL_CLOSED;
        return r;
    endfunction

    always_comb begin
        t_step s;
        s = '{st: i_cur, armed: i_armed, rem: QR_NONE, add: QA_NONE, tact: TACT_NONE,
              secs: '0, note: NOTE_NONE, bad: 1'b0};
        if (i_cmd inside {CMD_START_CLIENT, CMD_START_SERVER, CMD_START_LISTEN}) begin
            if (i_cur != ST_PURGED && i_cur != ST_SRV_CLOSED) begin
                s.bad = 1'b1;
            end else if (i_cmd == CMD_START_CLIENT) begin
                if (i_cfg.start_delay == '0) begin
                    s.add = QA_TO_OPEN_NRS;
                    s.st  = ST_CL_TO_OPEN;
                end else begin
                    s.add = QA_TO_INIT;
                    s = f_arm(s, i_cfg.start_delay);
                    s.st  = ST_CL_TO_INIT;
                end
            end else if (i_cmd == CMD_START_SERVER) begin
                // server opening passes straight through to open
                s.st   = ST_SRV_OPEN;
                s.note = NOTE_UP;
            end else begin
                s.st = ST_LISTEN;
            end
        end else begin
            if (i_cmd == CMD_TIMER) s.armed = 1'b0;  // expiry drops the armed bit
            case (i_cur)
                ST_CL_TO_INIT: begin
                    if (i_cmd == CMD_TIMER) begin
                        s.rem = QR_TO_INIT; s.add = QA_TO_OPEN; s.st = ST_CL_TO_OPEN;
                    end else if (i_cmd == CMD_PURGE) s = f_purge(s, QR_TO_INIT);
                    else s.bad = 1'b1;
                end
                ST_CL_TO_OPEN: begin
                    if (i_cmd == CMD_CONNECTING) begin
                        s.rem = QR_TO_OPEN; s.st = ST_CL_OPENING;
                    end else if (i_cmd == CMD_CONNECTED) begin
                        s.rem = QR_TO_OPEN; s = f_open_cl(s, i_cfg);
                    end else if (i_cmd == CMD_PURGE) s = f_purge(s, QR_TO_OPEN);
                    else s.bad = 1'b1;
                end
                ST_CL_OPENING: begin
                    if (i_cmd == CMD_CONNECTED) s = f_open_cl(s, i_cfg);
                    else if (i_cmd == CMD_CLOSING) s.st = ST_CL_CLOSING;
                    else if (i_cmd == CMD_PURGE) s = f_purge(s, QR_NONE);
                    else s.bad = 1'b1;
                end
                ST_CL_OPEN: begin
                    if (i_cmd == CMD_SEND_START) begin
                        s.add = QA_TO_SEND; s.st = ST_CL_SENDING;
                    end else if (i_cmd == CMD_CLOSING) begin
                        s = f_disarm(s); s.note = NOTE_DOWN; s.st = ST_CL_CLOSING;
                    end else if (i_cmd == CMD_SND_WIN || i_cmd == CMD_NO_SND_WIN) begin
                        s.st = i_cur;
                    end else if (i_cmd == CMD_TIMER) begin
                        s.add = QA_TO_CLOSE; s.st = ST_CL_TO_CLOSE;
                    end else if (i_cmd == CMD_PURGE) s = f_purge(s, QR_NONE);
                    else s.bad = 1'b1;
                end
                ST_CL_SENDING: begin
                    if (i_cmd == CMD_CLOSING) begin
                        s = f_disarm(s); s.rem = QR_TO_SEND; s.note = NOTE_DOWN;
                        s.st = ST_CL_CLOSING;
                    end else if (i_cmd == CMD_SND_WIN) begin
                        s.st = i_cur;
                    end else if (i_cmd == CMD_NO_SND_WIN) begin
                        s.rem = QR_TO_SEND; s.st = ST_CL_NO_SND_WIN;
                    end else if (i_cmd == CMD_TIMER) begin
                        s.rem = QR_TO_SEND; s.add = QA_TO_CLOSE; s.st = ST_CL_TO_CLOSE;
                    end else if (i_cmd == CMD_SEND_STOP) begin
                        s.rem = QR_TO_SEND; s.st = ST_CL_OPEN;
                    end else if (i_cmd == CMD_PURGE) s = f_purge(s, QR_TO_SEND);
                    else s.bad = 1'b1;
                end
                ST_CL_NO_SND_WIN: begin
                    if (i_cmd == CMD_CLOSING) begin
                        s = f_disarm(s); s.note = NOTE_DOWN; s.st = ST_CL_CLOSING;
                    end else if (i_cmd == CMD_TIMER) begin
                        s.add = QA_TO_CLOSE; s.st = ST_CL_TO_CLOSE;
                    end else if (i_cmd == CMD_SND_WIN) begin
                        s.add = QA_TO_SEND; s.st = ST_CL_SENDING;
                    end else if (i_cmd == CMD_SEND_STOP) s.st = ST_CL_OPEN;
                    else if (i_cmd == CMD_PURGE) s = f_purge(s, QR_NONE);
                    else s.bad = 1'b1;
                end
                ST_CL_TO_CLOSE: begin
                    if (i_cmd == CMD_CLOSING) begin
                        s.note = NOTE_DOWN; s.rem = QR_TO_CLOSE; s.st = ST_CL_CLOSING;
                    end else if (i_cmd == CMD_SEND_START || i_cmd == CMD_SEND_STOP) begin
                        s.st = i_cur;
                    end else if (i_cmd == CMD_PURGE) s = f_purge(s, QR_TO_CLOSE);
                    else s.bad = 1'b1;
                end
                ST_CL_CLOSING: begin
                    if (i_cmd == CMD_CLOSED) s = f_closed_cl(s, i_cfg);
                    else if (i_cmd == CMD_SEND_START || i_cmd == CMD_SEND_STOP) s.st = i_cur;
                    else if (i_cmd == CMD_PURGE) s = f_purge(s, QR_NONE);
                    else s.bad = 1'b1;
                end
                ST_CL_CLOSED: begin
                    if (i_cmd == CMD_TIMER) begin
                        s.rem = QR_CLOSED; s.add = QA_TO_OPEN; s.st = ST_CL_TO_OPEN;
                    end else if (i_cmd == CMD_PURGE) s = f_purge(s, QR_CLOSED);
                    else s.bad = 1'b1;
                end
                ST_SRV_OPEN: begin
                    if (i_cmd == CMD_SEND_START) begin
                        s.add = QA_TO_SEND; s.st = ST_SRV_SENDING;
                    end else if (i_cmd == CMD_CLOSING) begin
                        s.note = NOTE_DOWN; s.st = ST_SRV_CLOSING;
                    end else if (i_cmd == CMD_SND_WIN || i_cmd == CMD_NO_SND_WIN) begin
                        s.st = i_cur;
                    end else if (i_cmd == CMD_PURGE) s = f_purge(s, QR_NONE);
                    else s.bad = 1'b1;
                end
                ST_SRV_SENDING: begin
                    if (i_cmd == CMD_CLOSING) begin
                        s.rem = QR_TO_SEND; s.note = NOTE_DOWN; s.st = ST_SRV_CLOSING;
                    end else if (i_cmd == CMD_SND_WIN) begin
                        s.st = i_cur;
                    end else if (i_cmd == CMD_NO_SND_WIN) begin
                        s.rem = QR_TO_SEND; s.st = ST_SRV_NO_SND_WIN;
                    end else if (i_cmd == CMD_SEND_STOP) begin
                        s.rem = QR_TO_SEND; s.st = ST_SRV_OPEN;
                    end else if (i_cmd == CMD_PURGE) s = f_purge(s, QR_TO_SEND);
                    else s.bad = 1'b1;
                end
                ST_SRV_NO_SND_WIN: begin
                    if (i_cmd == CMD_CLOSING) begin
                        s = f_disarm(s); s.note = NOTE_DOWN; s.st = ST_SRV_CLOSING;
                    end else if (i_cmd == CMD_SND_WIN) begin
                        s.add = QA_TO_SEND; s.st = ST_SRV_SENDING;
                    end else if (i_cmd == CMD_SEND_STOP) s.st = ST_SRV_OPEN;
                    else if (i_cmd == CMD_PURGE) s = f_purge(s, QR_NONE);
                    else s.bad = 1'b1;
                end
                ST_SRV_CLOSING: begin
                    if (i_cmd == CMD_CLOSED) s.st = ST_SRV_CLOSED;
                    else if (i_cmd == CMD_SEND_START || i_cmd == CMD_SEND_STOP) s.st = i_cur;
                    else if (i_cmd == CMD_PURGE) s = f_purge(s, QR_NONE);
                    else s.bad = 1'b1;
                end
                ST_LISTEN: begin
                    if (i_cmd == CMD_PURGE) s = f_purge(s, QR_NONE);
                    else s.bad = 1'b1;
                end
                ST_PURGED: begin
                    if (i_cmd == CMD_CLOSING || i_cmd == CMD_CLOSED) s.st = i_cur;
                    else s.bad = 1'b1;
                end
                // srv_closed, the transient server-opening code and unused codes
                default: s.bad = 1'b1;
            endcase
        end
        o_step = s;
    end

endmodule

@@ sv/session_test_state_machine.sv @@
// Top level: per-session test state table with a read-modify-write memory.
//
// Each input item names a session and a command. The session's state code and
// timer-armed bit live in one synchronous memory (one 6-bit entry per session).
// For each item, the accept edge launches the memory read, and the update
// step in the CALC state then runs the transition, writes the entry back and
// loads the output register. s_axis_tready is high only in the idle state, so
// the block takes no new item until the previous one has left the update step.
// The output register holds a finished result until it is taken, and the next
// item is accepted meanwhile; the update step waits only if the previous
// result is still unclaimed. After reset a clearing pass writes "purged,
// not armed" to every entry, one per cycle, with s_axis_tready low. Config
// writes are taken at any time but should only be issued while the block is
// idle. A session index at or above NUM_SESSIONS reports purged with the
// illegal flag and touches nothing. Timer durations are seconds times 1e6,
// from one 16x20 multiply.
module session_test_state_machine #(
    parameter int NUM_SESSIONS = sts_pkg::NUM_SESSIONS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // [9:0] session_index, [13:10] command, [15:14] zero
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [sts_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // [9:0] result_session, [14:10] new_state, [17:15] queue_removed,
    // [20:18] queue_added, [22:21] timer_action, [58:23] timer_microseconds,
    // [60:59] notify, [61] illegal_event, [63:62] zero
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [sts_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [sts_pkg::CFG_A_W-1:0]   i_cfg_addr,
    input  logic [sts_pkg::SECS_W-1:0]    i_cfg_wdata
);
    import sts_pkg::*;

    localparam int DEPTH = (NUM_SESSIONS < (1 << IDX_W)) ? NUM_SESSIONS : (1 << IDX_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ENT_W = ST_W + 1;

    typedef enum logic [2:0] {
        CS_CLEAR = 3'b001,
        CS_IDLE  = 3'b010,
        CS_CALC  = 3'b100
    } t_ctl_state;

    t_ctl_state            r_cs, n_cs;
    logic [AW-1:0]         r_clr_addr;
    logic [ENT_W-1:0]      r_mem [DEPTH];
    logic [ENT_W-1:0]      r_rd;
    logic [IDX_W-1:0]      r_idx;
    logic [CMD_W-1:0]      r_cmd;
    t_cfg                  r_cfg;
    logic                  r_m_valid;
    logic [M_DATA_W-1:0]   r_m_data, n_m_data;

    t_step                 w_step;
    logic [TUS_W-1:0]      w_tus;
    logic                  w_in_range;
    logic                  w_accept;
    logic                  w_fire;      // update step completes this cycle
    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [ENT_W-1:0]      w_wr_data;

    assign s_axis_tready = (r_cs == CS_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_fire        = (r_cs == CS_CALC) && (!r_m_valid || m_axis_tready);
    assign w_in_range    = (32'(r_idx) < 32'(NUM_SESSIONS));

    // Control FSM
    always_comb begin
        n_cs = r_cs;
        case (r_cs)
            CS_CLEAR: if (r_clr_addr == AW'(DEPTH - 1)) n_cs = CS_IDLE;
            CS_IDLE:  if (w_accept) n_cs = CS_CALC;
            CS_CALC:  if (w_fire) n_cs = CS_IDLE;
            default:  n_cs = CS_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs       <= CS_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_cs <= n_cs;
            if (r_cs == CS_CLEAR) r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{start_delay: '0, uptime: '0, uptime_inf: 1'b1,
                       downtime: '0, downtime_inf: 1'b1};
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_START_DELAY: r_cfg.start_delay  <= i_cfg_wdata;
                CFG_UPTIME:      r_cfg.uptime       <= i_cfg_wdata;
                CFG_UPTIME_INF:  r_cfg.uptime_inf   <= i_cfg_wdata[0];
                CFG_DOWNTIME:    r_cfg.downtime     <= i_cfg_wdata;
                CFG_DOWN_INF:    r_cfg.downtime_inf <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx <= s_axis_tdata[IDX_W-1:0];
            r_cmd <= s_axis_tdata[IDX_W +: CMD_W];
        end
    end

    // Session table: one write port (clear pass or update), one registered read
    always_comb begin
        if (r_cs == CS_CLEAR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_addr;
            w_wr_data = {ST_PURGED, 1'b0};
        end else begin
            w_wr_en   = w_fire && w_in_range && !w_step.bad;
            w_wr_addr = r_idx[AW-1:0];
            w_wr_data = {w_step.st, w_step.armed};
        end
    end

    // read data is held through a stalled update step
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wr_addr] <= w_wr_data;
        if (w_accept) r_rd <= r_mem[s_axis_tdata[AW-1:0]];
    end

    sts_next u_next (
        .i_cur   (r_rd[ENT_W-1:1]),
        .i_armed (r_rd[0]),
        .i_cmd   (r_cmd),
        .i_cfg   (r_cfg),
        .o_step  (w_step)
    );

    // secs is zero unless a timer is set
    assign w_tus = 36'(w_step.secs) * 36'(USEC_PER_SEC);

    always_comb begin
        n_m_data = '0;
        n_m_data[IDX_W-1:0] = r_idx;
        if (!w_in_range) begin
            n_m_data[14:10] = ST_PURGED;
            n_m_data[61]    = 1'b1;
        end else if (w_step.bad) begin
            n_m_data[14:10] = r_rd[ENT_W-1:1];
            n_m_data[61]    = 1'b1;
        end else begin
            n_m_data[14:10] = w_step.st;
            n_m_data[17:15] = w_step.rem;
            n_m_data[20:18] = w_step.add;
            n_m_data[22:21] = w_step.tact;
            n_m_data[58:23] = w_tus;
            n_m_data[60:59] = w_step.note;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_fire) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) r_m_data <= n_m_data;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

@@ sv/sts_checker.sv @@
// Port-level checks for the session test state machine, bound to the top level.
module sts_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [sts_pkg::M_DATA_W-1:0]  m_axis_tdata
);
    import sts_pkg::*;

    a_rst_out_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while previous one in update");

    a_illegal_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[61] |-> m_axis_tdata[60:15] == '0)
        else $error("illegal result carries actions");

    a_timer_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[22:21] != TACT_SET |-> m_axis_tdata[58:23] == '0)
        else $error("timer duration without timer set");

endmodule

bind session_test_state_machine sts_checker u_sts_checker (.*);

@@ tb/sv/session_tracker_pkg.sv @@
// Session table tracker: predicts each result of the state machine and checks the outputs.
package session_tracker_pkg;
    import sts_pkg::*;

    // Same bit layout as m_axis_tdata: the last member sits in the lowest bits.
    typedef struct packed {
        logic [1:0]        pad;
        logic              bad;
        logic [NOTE_W-1:0] note;
        logic [TUS_W-1:0]  tus;
        logic [TACT_W-1:0] tact;
        logic [Q_W-1:0]    add;
        logic [Q_W-1:0]    rem;
        logic [ST_W-1:0]   st;
        logic [IDX_W-1:0]  sess;
    } t_session_result;

    class session_tracker;
        logic [ST_W-1:0]   state_tbl [NUM_SESSIONS_DEF];
        logic              armed_tbl [NUM_SESSIONS_DEF];
        logic [SECS_W-1:0] start_delay;
        logic [SECS_W-1:0] uptime;
        logic [SECS_W-1:0] downtime;
        logic              uptime_inf;
        logic              downtime_inf;
        t_session_result   awaited_results [$];
        int                errors;
        t_session_result   r;
        logic              armed_nxt;

        function new();
            foreach (state_tbl[k]) begin
                state_tbl[k] = ST_PURGED;
                armed_tbl[k] = 1'b0;
            end
            start_delay  = '0;
            uptime       = '0;
            uptime_inf   = 1'b1;
            downtime     = '0;
            downtime_inf = 1'b1;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_A_W-1:0] addr, logic [SECS_W-1:0] value);
            case (addr)
                CFG_START_DELAY: start_delay  = value;
                CFG_UPTIME:      uptime       = value;
                CFG_UPTIME_INF:  uptime_inf   = value[0];
                CFG_DOWNTIME:    downtime     = value;
                CFG_DOWN_INF:    downtime_inf = value[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void arm_timer(logic [SECS_W-1:0] secs);
            logic [63:0] usec;
            usec      = secs * 64'd1000000;
            r.tact    = TACT_SET;
            r.tus     = usec[TUS_W-1:0];
            armed_nxt = 1'b1;
        endfunction

        function void cancel_timer();
            if (armed_nxt) begin
                r.tact    = TACT_CANCEL;
                r.tus     = '0;
                armed_nxt = 1'b0;
            end
        endfunction

        function void enter_purged(logic [Q_W-1:0] from_q);
            r.rem = from_q;
            cancel_timer();
            r.st = ST_PURGED;
        endfunction

        function void enter_client_open();
            if (!uptime_inf) arm_timer(uptime);
            r.st   = ST_CL_OPEN;
            r.note = NOTE_UP;
        endfunction

        function void enter_client_closed();
            if (!downtime_inf) arm_timer(downtime);
            r.add = QA_CLOSED;
            r.st  = ST_CL_CLOSED;
        endfunction

        // One table read-modify-write; leaves the predicted result in r.
        function void advance_session(logic [IDX_W-1:0] idx, logic [CMD_W-1:0] cmd);
            logic [ST_W-1:0] cur;
            cur       = state_tbl[idx];
            r         = '0;
            r.sess    = idx;
            r.st      = cur;
            armed_nxt = armed_tbl[idx];
            if (cmd <= CMD_START_LISTEN) begin
                // starts are only taken from purged or a closed server
                if (cur != ST_PURGED && cur != ST_SRV_CLOSED) begin
                    r.bad = 1'b1;
                end else if (cmd == CMD_START_CLIENT) begin
                    if (start_delay == '0) begin
                        r.add = QA_TO_OPEN_NRS;
                        r.st  = ST_CL_TO_OPEN;
                    end else begin
                        r.add = QA_TO_INIT;
                        arm_timer(start_delay);
                        r.st = ST_CL_TO_INIT;
                    end
                end else if (cmd == CMD_START_SERVER) begin
                    r.st   = ST_SRV_OPEN;
                    r.note = NOTE_UP;
                end else begin
                    r.st = ST_LISTEN;
                end
            end else begin
                // an expiry has already fired, so the armed bit drops first
                if (cmd == CMD_TIMER) armed_nxt = 1'b0;
                case (cur)
                    ST_CL_TO_INIT: begin
                        if (cmd == CMD_TIMER) begin
                            r.rem = QR_TO_INIT; r.add = QA_TO_OPEN; r.st = ST_CL_TO_OPEN;
                        end else if (cmd == CMD_PURGE) enter_purged(QR_TO_INIT);
                        else r.bad = 1'b1;
                    end
                    ST_CL_TO_OPEN: begin
                        if (cmd == CMD_CONNECTING) begin
                            r.rem = QR_TO_OPEN; r.st = ST_CL_OPENING;
                        end else if (cmd == CMD_CONNECTED) begin
                            r.rem = QR_TO_OPEN; enter_client_open();
                        end else if (cmd == CMD_PURGE) enter_purged(QR_TO_OPEN);
                        else r.bad = 1'b1;
                    end
                    ST_CL_OPENING: begin
                        if (cmd == CMD_CONNECTED) enter_client_open();
                        else if (cmd == CMD_CLOSING) r.st = ST_CL_CLOSING;
                        else if (cmd == CMD_PURGE) enter_purged(QR_NONE);
                        else r.bad = 1'b1;
                    end
                    ST_CL_OPEN: begin
                        if (cmd == CMD_SEND_START) begin
                            r.add = QA_TO_SEND; r.st = ST_CL_SENDING;
                        end else if (cmd == CMD_CLOSING) begin
                            cancel_timer(); r.note = NOTE_DOWN; r.st = ST_CL_CLOSING;
                        end else if (cmd == CMD_SND_WIN || cmd == CMD_NO_SND_WIN) begin
                        end else if (cmd == CMD_TIMER) begin
                            r.add = QA_TO_CLOSE; r.st = ST_CL_TO_CLOSE;
                        end else if (cmd == CMD_PURGE) enter_purged(QR_NONE);
                        else r.bad = 1'b1;
                    end
                    ST_CL_SENDING: begin
                        if (cmd == CMD_CLOSING) begin
                            cancel_timer();
                            r.rem = QR_TO_SEND; r.note = NOTE_DOWN; r.st = ST_CL_CLOSING;
                        end else if (cmd == CMD_SND_WIN) begin
                        end else if (cmd == CMD_NO_SND_WIN) begin
                            r.rem = QR_TO_SEND; r.st = ST_CL_NO_SND_WIN;
                        end else if (cmd == CMD_TIMER) begin
                            r.rem = QR_TO_SEND; r.add = QA_TO_CLOSE; r.st = ST_CL_TO_CLOSE;
                        end else if (cmd == CMD_SEND_STOP) begin
                            r.rem = QR_TO_SEND; r.st = ST_CL_OPEN;
                        end else if (cmd == CMD_PURGE) enter_purged(QR_TO_SEND);
                        else r.bad = 1'b1;
                    end
                    ST_CL_NO_SND_WIN: begin
                        if (cmd == CMD_CLOSING) begin
                            cancel_timer(); r.note = NOTE_DOWN; r.st = ST_CL_CLOSING;
                        end else if (cmd == CMD_TIMER) begin
                            r.add = QA_TO_CLOSE; r.st = ST_CL_TO_CLOSE;
                        end else if (cmd == CMD_SND_WIN) begin
                            r.add = QA_TO_SEND; r.st = ST_CL_SENDING;
                        end else if (cmd == CMD_SEND_STOP) r.st = ST_CL_OPEN;
                        else if (cmd == CMD_PURGE) enter_purged(QR_NONE);
                        else r.bad = 1'b1;
                    end
                    ST_CL_TO_CLOSE: begin
                        if (cmd == CMD_CLOSING) begin
                            r.note = NOTE_DOWN; r.rem = QR_TO_CLOSE; r.st = ST_CL_CLOSING;
                        end else if (cmd == CMD_SEND_START || cmd == CMD_SEND_STOP) begin
                        end else if (cmd == CMD_PURGE) enter_purged(QR_TO_CLOSE);
                        else r.bad = 1'b1;
                    end
                    ST_CL_CLOSING: begin
                        if (cmd == CMD_CLOSED) enter_client_closed();
                        else if (cmd == CMD_SEND_START || cmd == CMD_SEND_STOP) begin
                        end else if (cmd == CMD_PURGE) enter_purged(QR_NONE);
                        else r.bad = 1'b1;
                    end
                    ST_CL_CLOSED: begin
                        if (cmd == CMD_TIMER) begin
                            r.rem = QR_CLOSED; r.add = QA_TO_OPEN; r.st = ST_CL_TO_OPEN;
                        end else if (cmd == CMD_PURGE) enter_purged(QR_CLOSED);
                        else r.bad = 1'b1;
                    end
                    ST_SRV_OPEN: begin
                        if (cmd == CMD_SEND_START) begin
                            r.add = QA_TO_SEND; r.st = ST_SRV_SENDING;
                        end else if (cmd == CMD_CLOSING) begin
                            r.note = NOTE_DOWN; r.st = ST_SRV_CLOSING;
                        end else if (cmd == CMD_SND_WIN || cmd == CMD_NO_SND_WIN) begin
                        end else if (cmd == CMD_PURGE) enter_purged(QR_NONE);
                        else r.bad = 1'b1;
                    end
                    ST_SRV_SENDING: begin
                        if (cmd == CMD_CLOSING) begin
                            r.rem = QR_TO_SEND; r.note = NOTE_DOWN; r.st = ST_SRV_CLOSING;
                        end else if (cmd == CMD_SND_WIN) begin
                        end else if (cmd == CMD_NO_SND_WIN) begin
                            r.rem = QR_TO_SEND; r.st = ST_SRV_NO_SND_WIN;
                        end else if (cmd == CMD_SEND_STOP) begin
                            r.rem = QR_TO_SEND; r.st = ST_SRV_OPEN;
                        end else if (cmd == CMD_PURGE) enter_purged(QR_TO_SEND);
                        else r.bad = 1'b1;
                    end
                    ST_SRV_NO_SND_WIN: begin
                        if (cmd == CMD_CLOSING) begin
                            cancel_timer(); r.note = NOTE_DOWN; r.st = ST_SRV_CLOSING;
                        end else if (cmd == CMD_SND_WIN) begin
                            r.add = QA_TO_SEND; r.st = ST_SRV_SENDING;
                        end else if (cmd == CMD_SEND_STOP) r.st = ST_SRV_OPEN;
                        else if (cmd == CMD_PURGE) enter_purged(QR_NONE);
                        else r.bad = 1'b1;
                    end
                    ST_SRV_CLOSING: begin
                        if (cmd == CMD_CLOSED) r.st = ST_SRV_CLOSED;
                        else if (cmd == CMD_SEND_START || cmd == CMD_SEND_STOP) begin
                        end else if (cmd == CMD_PURGE) enter_purged(QR_NONE);
                        else r.bad = 1'b1;
                    end
                    ST_LISTEN: begin
                        if (cmd == CMD_PURGE) enter_purged(QR_NONE);
                        else r.bad = 1'b1;
                    end
                    ST_PURGED: begin
                        if (cmd != CMD_CLOSING && cmd != CMD_CLOSED) r.bad = 1'b1;
                    end
                    default: r.bad = 1'b1;
                endcase
            end
            if (r.bad) begin
                // rejected: report the stored state, touch nothing
                r      = '0;
                r.sess = idx;
                r.st   = cur;
                r.bad  = 1'b1;
            end else begin
                state_tbl[idx] = r.st;
                armed_tbl[idx] = armed_nxt;
            end
        endfunction

        function void note_command(logic [S_DATA_W-1:0] data);
            advance_session(data[IDX_W-1:0], data[IDX_W+CMD_W-1:IDX_W]);
            awaited_results.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR: %s", msg);
        endtask

        task check_field(string name, logic [IDX_W-1:0] sess,
                         logic [TUS_W-1:0] got, logic [TUS_W-1:0] want);
            if (got !== want)
                report($sformatf("session %0d %s: got %0d, want %0d", sess, name, got, want));
        endtask

        task check_result(logic [M_DATA_W-1:0] data);
            t_session_result got;
            t_session_result want;
            got = data;
            if (awaited_results.size() == 0) begin
                report($sformatf("unexpected result for session %0d", got.sess));
            end else begin
                want = awaited_results.pop_front();
                check_field("result_session", want.sess, got.sess, want.sess);
                check_field("new_state", want.sess, got.st, want.st);
                check_field("queue_removed", want.sess, got.rem, want.rem);
                check_field("queue_added", want.sess, got.add, want.add);
                check_field("timer_action", want.sess, got.tact, want.tact);
                check_field("timer_microseconds", want.sess, got.tus, want.tus);
                check_field("notify", want.sess, got.note, want.note);
                check_field("illegal_event", want.sess, got.bad, want.bad);
            end
        endtask
    endclass

endpackage

@@ tb/sv/tb_top.sv @@
// Top-level testbench for the session test state machine.
module tb_top;
    import sts_pkg::*;
    import session_tracker_pkg::*;

    // Cycles without a handshake allowed: covers the clearing pass after reset
    // and the long receiver hold-off many times over.
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_ITEMS = 630;

    logic                clk   = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                cfg_we    = 1'b0;
    logic [CFG_A_W-1:0]  cfg_addr  = '0;
    logic [SECS_W-1:0]   cfg_wdata = '0;

    session_tracker sb;
    int send_idle_pct = 0;   // chance in 100 that the sender leaves a gap
    int recv_idle_pct = 0;   // chance in 100 that the receiver drops ready
    int results_taken = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    always #10 clk = ~clk;

    session_test_state_machine dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata)
    );

    // Result side: random back-pressure, plus a long hold-off twice in the run
    // (once with idling, once without) so the output register fills and the
    // block stops taking items while the sender keeps offering.
    always @(posedge clk) begin : result_side
        int hold_next;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            hold_next = (hold_left != 0) ? hold_left - 1 : 0;
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
                if (results_taken == 299 || results_taken == 1499) hold_next = HOLD_CYCLES;
                results_taken <= results_taken + 1;
            end
            hold_left     <= hold_next;
            m_axis_tready <= (hold_next == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: any handshake on either side counts as progress.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("session_test_state_machine: mismatch");
            $finish;
        end
    end

    // Offer one item, with an optional gap first; returns at the accept edge
    // with tvalid still high so back-to-back items need no extra assignment.
    task automatic send_item(logic [IDX_W-1:0] idx, logic [CMD_W-1:0] cmd);
        logic [S_DATA_W-1:0] item;
        item = {{(S_DATA_W-CMD_W-IDX_W){1'b0}}, cmd, idx};
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_command(item);
    endtask

    task automatic write_reg(logic [CFG_A_W-1:0] addr, logic [SECS_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        sb.write_reg(addr, value);
    endtask

    // Only called with nothing in flight.
    task automatic configure(logic [SECS_W-1:0] start_delay, logic [SECS_W-1:0] uptime,
                             logic uptime_inf, logic [SECS_W-1:0] downtime,
                             logic downtime_inf);
        write_reg(CFG_START_DELAY, start_delay);
        write_reg(CFG_UPTIME, uptime);
        write_reg(CFG_UPTIME_INF, {{(SECS_W-1){1'b0}}, uptime_inf});
        write_reg(CFG_DOWNTIME, downtime);
        write_reg(CFG_DOWN_INF, {{(SECS_W-1){1'b0}}, downtime_inf});
        cfg_we <= 1'b0;
    endtask

    // Every item yields one result, so an empty table of awaited results
    // means the block is idle.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly a command that the session's predicted state accepts, so that
    // sessions walk deep into the client and server flows; some purges and
    // a few arbitrary codes break the sequences up.
    function automatic logic [CMD_W-1:0] pick_command(logic [IDX_W-1:0] idx);
        logic [CMD_W-1:0] legal [$];
        case (sb.state_tbl[idx])
            ST_CL_TO_INIT, ST_CL_CLOSED: legal = '{CMD_TIMER};
            ST_CL_TO_OPEN:     legal = '{CMD_CONNECTING, CMD_CONNECTED};
            ST_CL_OPENING:     legal = '{CMD_CONNECTED, CMD_CLOSING};
            ST_CL_OPEN:        legal = '{CMD_SEND_START, CMD_CLOSING, CMD_SND_WIN,
                                         CMD_NO_SND_WIN, CMD_TIMER};
            ST_CL_SENDING:     legal = '{CMD_CLOSING, CMD_SND_WIN, CMD_NO_SND_WIN,
                                         CMD_TIMER, CMD_SEND_STOP};
            ST_CL_NO_SND_WIN:  legal = '{CMD_CLOSING, CMD_TIMER, CMD_SND_WIN, CMD_SEND_STOP};
            ST_CL_TO_CLOSE:    legal = '{CMD_CLOSING, CMD_SEND_START, CMD_SEND_STOP};
            ST_CL_CLOSING, ST_SRV_CLOSING:
                               legal = '{CMD_CLOSED, CMD_SEND_START, CMD_SEND_STOP};
            ST_SRV_OPEN:       legal = '{CMD_SEND_START, CMD_CLOSING, CMD_SND_WIN,
                                         CMD_NO_SND_WIN};
            ST_SRV_SENDING:    legal = '{CMD_CLOSING, CMD_SND_WIN, CMD_NO_SND_WIN,
                                         CMD_SEND_STOP};
            ST_SRV_NO_SND_WIN: legal = '{CMD_CLOSING, CMD_SND_WIN, CMD_SEND_STOP};
            ST_SRV_CLOSED:     legal = '{CMD_START_CLIENT, CMD_START_SERVER, CMD_START_LISTEN};
            ST_PURGED:         legal = '{CMD_START_CLIENT, CMD_START_CLIENT, CMD_START_SERVER,
                                         CMD_START_LISTEN, CMD_CLOSED};
            default:           legal = '{CMD_PURGE};
        endcase
        if ($urandom_range(0, 99) < 8) return CMD_PURGE;
        if ($urandom_range(0, 99) < 7) return CMD_W'($urandom_range(0, 15));
        return legal[$urandom_range(0, legal.size() - 1)];
    endfunction

    // Most items go to a handful of sessions so their flows get deep; the
    // rest hit any index, which also toggles every index bit.
    task automatic run_random(int count);
        logic [IDX_W-1:0] pool [8];
        logic [IDX_W-1:0] idx;
        foreach (pool[k]) pool[k] = IDX_W'($urandom_range(0, NUM_SESSIONS_DEF - 1));
        repeat (count) begin
            if ($urandom_range(0, 9) < 8)
                idx = pool[$urandom_range(0, 7)];
            else
                idx = IDX_W'($urandom_range(0, NUM_SESSIONS_DEF - 1));
            send_item(idx, pick_command(idx));
        end
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Largest delays with both timers live: start delay, uptime and
        // downtime all set the widest microsecond count.
        configure('1, '1, 1'b0, '1, 1'b0);

        // Directed: a full client life on session 0, including re-arm,
        // expiry and a purge that cancels a live timer.
        send_item(10'd0, CMD_START_CLIENT);
        send_item(10'd0, CMD_START_CLIENT);    // start outside purged: illegal
        send_item(10'd0, CMD_TIMER);
        send_item(10'd0, CMD_CONNECTING);
        send_item(10'd0, CMD_CONNECTED);
        send_item(10'd0, CMD_SEND_START);
        send_item(10'd0, CMD_NO_SND_WIN);
        send_item(10'd0, CMD_SND_WIN);
        send_item(10'd0, CMD_TIMER);
        send_item(10'd0, CMD_SEND_STOP);
        send_item(10'd0, CMD_CLOSING);
        send_item(10'd0, CMD_CLOSED);
        send_item(10'd0, CMD_PURGE);
        send_item(10'd0, CMD_CLOSED);
        // Server and listener on the top index, with codes above the range.
        send_item(10'd1023, CMD_START_SERVER);
        send_item(10'd1023, CMD_W'(15));
        send_item(10'd1023, CMD_SEND_START);
        send_item(10'd1023, CMD_CLOSING);
        send_item(10'd1023, CMD_CLOSED);
        send_item(10'd1023, CMD_START_LISTEN);
        send_item(10'd1023, CMD_W'(13));
        send_item(10'd1023, CMD_PURGE);
        send_item(10'd682, CMD_TIMER);         // expiry with nothing running
        send_item(10'd682, CMD_W'(14));
        send_item(10'd682, CMD_START_CLIENT);
        wait_drained();

        // Zero delays: immediate client start, zero-length timers.
        configure('0, '0, 1'b0, '0, 1'b0);
        send_idle_pct = 27;
        recv_idle_pct = 48;
        run_random(PHASE_ITEMS);
        wait_drained();

        // Infinite up and down times.
        configure('0, SECS_W'($urandom_range(0, 65535)), 1'b1,
                  SECS_W'($urandom_range(0, 65535)), 1'b1);
        send_idle_pct = 48;
        recv_idle_pct = 27;
        run_random(PHASE_ITEMS);
        wait_drained();

        // Arbitrary settings, no idling on either side.
        configure(SECS_W'($urandom_range(0, 65535)), SECS_W'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)), SECS_W'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_ITEMS);
        wait_drained();
        repeat (8) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("session_test_state_machine: match");
        else
            $display("session_test_state_machine: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
sv/sts_pkg.sv
sv/sts_next.sv
sv/session_test_state_machine.sv
sv/sts_checker.sv
tb/sv/session_tracker_pkg.sv
tb/sv/tb_top.sv
